FILE: rtl/ikc_pkg.sv
`timescale 1ns / 1ps

package ikc_pkg;

    localparam int KW_COUNT  = 35;
    localparam int KW_MAXLEN = 14;
    localparam int KIND_W    = 6;
    localparam int LEN_W     = 8;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [KIND_W-1:0] KIND_IDENT = 6'd0;
    localparam logic [LEN_W-1:0]  LEN_SAT    = 8'hFF;

    // keyword text, right aligned: last character in the low byte
    localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "if", "int", "else", "elif", "case", "line", "long", "true", "bool",
        "auto", "while", "embed", "undef", "error", "endif", "false",
        "elifdef", "include", "warning", "defined", "alignas", "alignof",
        "typedef", "nullptr", "pragma", "extern", "static", "inline", "define",
        "elifndef", "register", "restrict", "constexpr", {"_STATIC", "_ASSERT"},
        {"STATIC", "_ASSERT"}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8,
        4'd8, 4'd8, 4'd9, 4'd14, 4'd13
    };

    // classified character as it travels from front to back
    typedef struct packed {
        logic [7:0] code;
        logic       is_ident;
    } char_item_t;

    // word tracking state visible to the top level
    typedef struct packed {
        logic in_word;
        logic discarding;
    } back_status_t;

    // character of keyword k at position p, zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
        logic [3:0] idx;
        begin
            idx = KW_LEN[k] - 4'd1 - p;
            if (p < KW_LEN[k])
                return KW_TEXT[k][{idx, 3'b000} +: 8];
            else
                return 8'h00;
        end
    endfunction

endpackage

FILE: rtl/ikc_front.sv
`timescale 1ns / 1ps

module ikc_front
(
    input  logic [7:0]              char_code,
    output ikc_pkg::char_item_t     item
);

    logic is_lower;
    logic is_upper;
    logic is_digit;

    // letters, digits and underscore extend a word; high bytes never do
    assign is_lower = (char_code >= 8'h61) && (char_code <= 8'h7A);
    assign is_upper = (char_code >= 8'h41) && (char_code <= 8'h5A);
    assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);

    assign item.code     = char_code;
    assign item.is_ident = is_lower || is_upper || is_digit || (char_code == 8'h5F);

endmodule

FILE: rtl/ikc_queue.sv
`timescale 1ns / 1ps

module ikc_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push_valid,
    output logic                                push_ready,
    input  ikc_pkg::char_item_t                 push_item,
    output logic                                pop_valid,
    input  logic                                pop_ready,
    output ikc_pkg::char_item_t                 pop_item,
    output logic [ikc_pkg::QUEUE_CNT_W-1:0]     fill
);

    ikc_pkg::char_item_t slot_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [ikc_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign fill       = count_reg;

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots need no reset
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/ikc_back.sv
`timescale 1ns / 1ps

module ikc_back
#(
    parameter int LEXEME_CAPACITY = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ikc_pkg::char_item_t                 item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ikc_pkg::KIND_W-1:0]          token_kind,
    output logic [ikc_pkg::LEN_W-1:0]           word_length,
    output logic                                overflow_flag,
    output ikc_pkg::back_status_t               status
);

    localparam int LW = $clog2(LEXEME_CAPACITY);
    localparam logic [LW-1:0] LEN_LAST = LW'(LEXEME_CAPACITY - 1);

    logic [LW-1:0]                len_reg, len_next;
    logic [ikc_pkg::KW_COUNT-1:0] mask_reg, mask_next;
    logic                         in_word_reg, in_word_next;
    logic                         discarding_reg, discarding_next;

    logic                         out_valid_reg, out_valid_next;
    logic [ikc_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [ikc_pkg::LEN_W-1:0]    length_reg, length_next;
    logic                         ovf_reg, ovf_next;

    logic [ikc_pkg::KW_COUNT-1:0] keep;
    logic [ikc_pkg::KIND_W-1:0]   match_kind;
    logic                         pop;

    function automatic logic [ikc_pkg::LEN_W-1:0] sat_len(input logic [LW:0] n);
        begin
            if (n > (LW+1)'(255))
                return ikc_pkg::LEN_SAT;
            else
                return ikc_pkg::LEN_W'(n);
        end
    endfunction

    assign pop        = item_valid && (!out_valid_reg || out_ready);
    assign item_ready = !out_valid_reg || out_ready;

    // per-keyword position compare against the current character
    always_comb
    begin
        for (int k = 0; k < ikc_pkg::KW_COUNT; k++)
        begin
            keep[k] = (len_reg < LW'(ikc_pkg::KW_LEN[k])) &&
                      (ikc_pkg::kw_char(k, len_reg[3:0]) == item.code);
        end
    end

    // lowest surviving keyword of exactly this length wins
    always_comb
    begin
        match_kind = ikc_pkg::KIND_IDENT;
        for (int k = ikc_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (mask_reg[k] && (len_reg == LW'(ikc_pkg::KW_LEN[k])))
                match_kind = ikc_pkg::KIND_W'(k + 1);
        end
    end

    always_comb
    begin
        len_next        = len_reg;
        mask_next       = mask_reg;
        in_word_next    = in_word_reg;
        discarding_next = discarding_reg;
        kind_next       = kind_reg;
        length_next     = length_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (pop)
        begin
            if (item.is_ident)
            begin
                if (!discarding_reg)
                begin
                    if (len_reg == LEN_LAST)
                    begin
                        out_valid_next  = 1'b1;
                        kind_next       = ikc_pkg::KIND_IDENT;
                        length_next     = sat_len({1'b0, len_reg} + (LW+1)'(1));
                        ovf_next        = 1'b1;
                        len_next        = '0;
                        mask_next       = '1;
                        in_word_next    = 1'b0;
                        discarding_next = 1'b1;
                    end
                    else
                    begin
                        mask_next    = mask_reg & keep;
                        len_next     = len_reg + LW'(1);
                        in_word_next = 1'b1;
                    end
                end
            end
            else if (discarding_reg)
            begin
                discarding_next = 1'b0;
            end
            else if (in_word_reg)
            begin
                out_valid_next = 1'b1;
                kind_next      = match_kind;
                length_next    = sat_len({1'b0, len_reg});
                ovf_next       = 1'b0;
                len_next       = '0;
                mask_next      = '1;
                in_word_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            mask_reg       <= '1;
            in_word_reg    <= 1'b0;
            discarding_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            len_reg        <= len_next;
            mask_reg       <= mask_next;
            in_word_reg    <= in_word_next;
            discarding_reg <= discarding_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        length_reg <= length_next;
        ovf_reg    <= ovf_next;
    end

    assign out_valid         = out_valid_reg;
    assign token_kind        = kind_reg;
    assign word_length       = length_reg;
    assign overflow_flag     = ovf_reg;
    assign status.in_word    = in_word_reg;
    assign status.discarding = discarding_reg;

endmodule

FILE: rtl/identifier_keyword_classifier.sv
`timescale 1ns / 1ps

// identifier and keyword classifier: takes one source byte per cycle on
// char_code and, at the first separator after a word, returns one result with
// token_kind (0 identifier, 1..35 keywords) and word_length; a word longer than
// LEXEME_CAPACITY-1 characters returns one overflow result and the rest of it is
// dropped. sustained rate is one byte per cycle while out_ready takes each
// result, set by the mask update in the back end (35 parallel compares);
// with the queue empty a separator passes a queue slot and the output register
// before its result is valid; a result held by out_ready stalls the back end

module identifier_keyword_classifier
#(
    parameter int LEXEME_CAPACITY = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      char_code,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ikc_pkg::KIND_W-1:0]      token_kind,
    output logic [ikc_pkg::LEN_W-1:0]       word_length,
    output logic                            overflow_flag
);

    ikc_pkg::char_item_t              front_item;
    ikc_pkg::char_item_t              back_item;
    logic                             back_valid;
    logic                             back_ready;
    logic [ikc_pkg::QUEUE_CNT_W-1:0]  queue_fill;
    ikc_pkg::back_status_t            status;

    // front end: classify each byte as identifier character or separator
    ikc_front u_front
    (
        .char_code (char_code),
        .item      (front_item)
    );

    // two-entry queue decouples input acceptance from back end stalls
    ikc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item),
        .fill       (queue_fill)
    );

    // back end: word length, candidate mask, discard state and result register
    ikc_back
    #(
        .LEXEME_CAPACITY (LEXEME_CAPACITY)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (back_valid),
        .item_ready    (back_ready),
        .item          (back_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .token_kind    (token_kind),
        .word_length   (word_length),
        .overflow_flag (overflow_flag),
        .status        (status)
    );

    // queue never holds more than its two slots
    assert property (@(posedge clk) disable iff (!rst_n) queue_fill != 2'd3)
        else $error("queue fill out of range");

    // an overflow result always reports an identifier kind
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow_flag) |-> (token_kind == ikc_pkg::KIND_IDENT))
        else $error("overflow result with keyword kind");

    // while dropping an overlong word no new word is open
    assert property (@(posedge clk) disable iff (!rst_n)
        status.discarding |-> !status.in_word)
        else $error("word open while discarding");

    // results carry a nonzero length and a kind within the keyword list
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((word_length != '0) &&
                       (token_kind <= ikc_pkg::KIND_W'(ikc_pkg::KW_COUNT))))
        else $error("malformed result");

endmodule
